>>> design/lpl_pkg.sv
// Package for the lookahead peak limiter: formats, register indexes and sequencer states.
package lpl_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ENV_W        = 24;
    localparam int ENV_SHIFT    = ENV_W - SAMPLE_WIDTH;
    localparam int GAIN_W       = 17;
    localparam int COEF_W       = 16;
    localparam int LIMIT_W      = 15;
    localparam int LEN_W        = 11;
    localparam int QUOT_W       = 16;
    localparam int FRAC_BITS    = 16;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 5;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);
    localparam int CLIP_MAG = (999 * (2 ** (SAMPLE_WIDTH - 1))) / 1000;

    typedef enum logic [2:0] {
        REG_LIMIT       = 3'd0,
        REG_ATTACK      = 3'd1,
        REG_RELEASE     = 3'd2,
        REG_ENV_RELEASE = 3'd3,
        REG_LOOKAHEAD   = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV,
        S_ENV_SUB,
        S_DIV_SETUP,
        S_DIV,
        S_GAIN_MUL,
        S_GAIN_UPD,
        S_OUT_MUL,
        S_OUT
    } lpl_state_t;

endpackage

>>> design/lookahead_peak_limiter.sv
// Lookahead peak limiter: envelope, gain divider, gain smoothing and delay-line memory.
// An accepted sample passes through the envelope, divider, gain and output states in order;
// the restoring divider runs only while the envelope exceeds the limit.
// The sequencer handles one sample at a time and takes no new one until the last is output.
// Reset: registers take their reset values at once; a clearing pass then zeroes the delay
// line, one entry a cycle, from the first entry to the last, during which no sample is accepted.
module lookahead_peak_limiter #(
    parameter int MAX_LOOKAHEAD = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpl_pkg::ADDR_W-1:0]          paddr,
    input  logic [lpl_pkg::DATA_W-1:0]          pwdata,
    output logic [lpl_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lpl_pkg::SAMPLE_WIDTH-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lpl_pkg::SAMPLE_WIDTH-1:0] sample_out,
    output logic [lpl_pkg::GAIN_W-1:0]          gain_now
);
    import lpl_pkg::*;

    localparam int AW    = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
    localparam int CW    = $clog2(MAX_LOOKAHEAD + 1);
    localparam int CMPW  = (CW > LEN_W) ? CW : LEN_W;
    localparam int MUL_AW = ENV_W + 1;
    localparam int MUL_BW = GAIN_W + 1;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int CNT_W = $clog2(QUOT_W);

    localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_LOOKAHEAD - 1);
    localparam logic [CMPW-1:0] MAX_LEN  = CMPW'(MAX_LOOKAHEAD);
    localparam logic signed [MUL_PW-1:0] CLIP_P   = MUL_PW'(CLIP_MAG);
    localparam logic signed [MUL_PW-1:0] CLIP_N   = -CLIP_P;
    localparam logic signed [MUL_PW-1:0] ROUND_HALF = MUL_PW'(2 ** (FRAC_BITS - 1));

    // Configuration registers.
    logic [LIMIT_W-1:0] limit_reg;
    logic [COEF_W-1:0]  attack_reg;
    logic [COEF_W-1:0]  release_reg;
    logic [COEF_W-1:0]  env_rel_reg;
    logic [LEN_W-1:0]   len_reg;

    logic     cfg_wr;
    cfg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_W'(29491);
            attack_reg  <= COEF_W'(6554);
            release_reg <= COEF_W'(66);
            env_rel_reg <= COEF_W'(66);
            len_reg     <= LEN_W'(48);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_LIMIT:       limit_reg   <= pwdata[LIMIT_W-1:0];
                REG_ATTACK:      attack_reg  <= pwdata[COEF_W-1:0];
                REG_RELEASE:     release_reg <= pwdata[COEF_W-1:0];
                REG_ENV_RELEASE: env_rel_reg <= pwdata[COEF_W-1:0];
                REG_LOOKAHEAD:   len_reg     <= pwdata[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_LIMIT:       prdata = DATA_W'(limit_reg);
            REG_ATTACK:      prdata = DATA_W'(attack_reg);
            REG_RELEASE:     prdata = DATA_W'(release_reg);
            REG_ENV_RELEASE: prdata = DATA_W'(env_rel_reg);
            REG_LOOKAHEAD:   prdata = DATA_W'(len_reg);
            default:         prdata = '0;
        endcase
    end

    // Datapath and sequencer registers.
    lpl_state_t state_reg, state_next;
    logic                        clr_reg, clr_next;
    logic [AW-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]               widx_reg, widx_next;
    logic [ENV_W-1:0]            env_reg, env_next;
    logic [GAIN_W-1:0]           gain_reg, gain_next;
    logic [GAIN_W-1:0]           gdes_reg, gdes_next;
    logic                        down_reg, down_next;
    logic [ENV_W-1:0]            rem_reg, rem_next;
    logic [QUOT_W-1:0]           quot_reg, quot_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic signed [MUL_PW-1:0]    prod_reg, prod_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg, sample_out_next;
    logic [GAIN_W-1:0]           gain_out_reg, gain_out_next;

    // Delay-line memory.
    logic signed [SAMPLE_WIDTH-1:0] delay_mem [0:MAX_LOOKAHEAD-1];
    logic signed [SAMPLE_WIDTH-1:0] mem_rd_reg;
    logic                           mem_re;
    logic                           mem_we;
    logic [AW-1:0]                  mem_wa;
    logic signed [SAMPLE_WIDTH-1:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            delay_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_rd_reg <= delay_mem[widx_reg];
        end
    end

    // Combinational helpers.
    logic [SAMPLE_WIDTH-1:0]     abs_x;
    logic [ENV_W-1:0]            mag;
    logic [ENV_W-1:0]            lim;
    logic [ENV_W:0]              rem_dbl;
    logic                        quot_bit;
    logic [CMPW-1:0]             len_eff;
    logic [CMPW-1:0]             idx_inc;
    logic signed [MUL_AW-1:0]    mul_a;
    logic signed [MUL_BW-1:0]    mul_b;
    logic signed [MUL_PW-1:0]    rnd;
    logic                        in_acc;
    logic                        out_free;

    assign abs_x   = x_reg[SAMPLE_WIDTH-1] ? (~x_reg + 1'b1) : x_reg;
    assign mag     = ENV_W'(abs_x) << ENV_SHIFT;
    assign lim     = ENV_W'(limit_reg) << ENV_SHIFT;
    assign rem_dbl = {rem_reg, 1'b0};
    assign quot_bit = (rem_dbl >= {1'b0, env_reg});
    assign idx_inc = CMPW'(widx_reg) + CMPW'(1);
    assign rnd     = (prod_reg + ROUND_HALF) >>> FRAC_BITS;

    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = CMPW'(1);
        end
        else if (CMPW'(len_reg) > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = CMPW'(len_reg);
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || clr_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign gain_now  = gain_out_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        clr_cnt_next    = clr_cnt_reg;
        widx_next       = widx_reg;
        env_next        = env_reg;
        gain_next       = gain_reg;
        gdes_next       = gdes_reg;
        down_next       = down_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        cnt_next        = cnt_reg;
        x_next          = x_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && out_stall;
        sample_out_next = sample_out_reg;
        gain_out_next   = gain_out_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = widx_reg;
        mem_wd          = x_reg;
        mul_a           = MUL_AW'($signed({1'b0, env_reg - mag}));
        mul_b           = MUL_BW'($signed({1'b0, env_rel_reg}));

        if (clr_reg)
        begin
            mem_we       = 1'b1;
            mem_wa       = clr_cnt_reg;
            mem_wd       = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ENTRY)
            begin
                clr_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    x_next     = sample_in;
                    mem_re     = 1'b1;
                    state_next = S_ENV;
                end
            end
            S_ENV:
            begin
                // The old sample was read last cycle; the new one replaces it now.
                mem_we    = 1'b1;
                widx_next = (idx_inc >= len_eff) ? '0 : idx_inc[AW-1:0];
                if (mag > env_reg)
                begin
                    env_next   = mag;
                    state_next = S_DIV_SETUP;
                end
                else
                begin
                    prod_next  = mul_a * mul_b;
                    state_next = S_ENV_SUB;
                end
            end
            S_ENV_SUB:
            begin
                env_next   = env_reg - rnd[ENV_W-1:0];
                state_next = S_DIV_SETUP;
            end
            S_DIV_SETUP:
            begin
                if (env_reg > lim)
                begin
                    rem_next   = lim;
                    quot_next  = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    gdes_next  = UNITY_GAIN;
                    state_next = S_GAIN_MUL;
                end
            end
            S_DIV:
            begin
                // Restoring division; the remainder stays below the envelope throughout.
                rem_next  = quot_bit ? ENV_W'(rem_dbl - {1'b0, env_reg}) : rem_dbl[ENV_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], quot_bit};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUOT_W - 1))
                begin
                    gdes_next  = GAIN_W'({quot_reg[QUOT_W-2:0], quot_bit});
                    state_next = S_GAIN_MUL;
                end
            end
            S_GAIN_MUL:
            begin
                if (gdes_reg < gain_reg)
                begin
                    down_next = 1'b1;
                    mul_a     = MUL_AW'($signed({1'b0, gain_reg - gdes_reg}));
                    mul_b     = MUL_BW'($signed({1'b0, attack_reg}));
                end
                else
                begin
                    down_next = 1'b0;
                    mul_a     = MUL_AW'($signed({1'b0, gdes_reg - gain_reg}));
                    mul_b     = MUL_BW'($signed({1'b0, release_reg}));
                end
                prod_next  = mul_a * mul_b;
                state_next = S_GAIN_UPD;
            end
            S_GAIN_UPD:
            begin
                gain_next  = down_reg ? (gain_reg - rnd[GAIN_W-1:0])
                                      : (gain_reg + rnd[GAIN_W-1:0]);
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                mul_a      = MUL_AW'(mem_rd_reg);
                mul_b      = MUL_BW'($signed({1'b0, gain_reg}));
                prod_next  = mul_a * mul_b;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (rnd > CLIP_P)
                    begin
                        sample_out_next = SAMPLE_WIDTH'(CLIP_P);
                    end
                    else if (rnd < CLIP_N)
                    begin
                        sample_out_next = SAMPLE_WIDTH'(CLIP_N);
                    end
                    else
                    begin
                        sample_out_next = rnd[SAMPLE_WIDTH-1:0];
                    end
                    gain_out_next  = gain_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            widx_reg      <= '0;
            env_reg       <= '0;
            gain_reg      <= UNITY_GAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_cnt_reg   <= clr_cnt_next;
            widx_reg      <= widx_next;
            env_reg       <= env_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gdes_reg       <= gdes_next;
        down_reg       <= down_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        cnt_reg        <= cnt_next;
        x_reg          <= x_next;
        prod_reg       <= prod_next;
        sample_out_reg <= sample_out_next;
        gain_out_reg   <= gain_out_next;
    end

    // The write index never leaves the memory.
    a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(widx_reg) < MAX_LEN)
        else $error("write index beyond delay line");

    // Smoothing never carries the gain past unity.
    a_gain_unity: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= UNITY_GAIN)
        else $error("gain above unity");

    // The divider remainder stays below the divisor on every step.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < env_reg))
        else $error("divider remainder not below envelope");

    // No sample is taken while the delay line is being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |=> (state_reg == S_IDLE))
        else $error("sample accepted during clearing pass");

    // A delivered sample always lies within the clip range.
    a_out_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((sample_out_reg <= SAMPLE_WIDTH'(CLIP_P))
                        && (sample_out_reg >= SAMPLE_WIDTH'(CLIP_N))))
        else $error("output sample outside clip range");

endmodule

>>> verif/lookahead_peak_limiter_tb.sv
// Self-checking testbench for the lookahead peak limiter, with its own transaction-level model.
`timescale 1ns / 100ps

module tb;
    import lpl_pkg::*;

    localparam int          DELAY_DEPTH   = 1024;
    localparam int          SAT_LEVEL     = 32735;
    localparam int          FULL_GAIN     = 65536;
    localparam int          CYCLE_LIMIT   = 800000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          PHASE_ITEMS   = 300;
    localparam logic [2:0]  REG_UNMAPPED  = 3'd6;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef enum int {
        BURST_QUIET,
        BURST_MID,
        BURST_LOUD,
        BURST_EXTREME
    } burst_kind_t;

    typedef struct {
        logic signed [15:0] sample;
        logic [16:0]        gain;
    } limiter_output_t;

    class limiter_tracker;
        bit [14:0]          limit_level;
        bit [15:0]          attack_coef;
        bit [15:0]          release_coef;
        bit [15:0]          env_release_coef;
        bit [10:0]          lookahead_len;
        bit [23:0]          envelope;
        bit [16:0]          gain;
        bit signed [15:0]   delay_mem [DELAY_DEPTH];
        int unsigned        wr_index;
        limiter_output_t    due_outputs [$];
        int                 errors;

        function new();
            limit_level      = 15'd29491;
            attack_coef      = 16'd6554;
            release_coef     = 16'd66;
            env_release_coef = 16'd66;
            lookahead_len    = 11'd48;
            envelope         = '0;
            gain             = 17'(FULL_GAIN);
            foreach (delay_mem[i])
                delay_mem[i] = '0;
            wr_index         = 0;
            errors           = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_LIMIT:       limit_level      = value[14:0];
                REG_ATTACK:      attack_coef      = value[15:0];
                REG_RELEASE:     release_coef     = value[15:0];
                REG_ENV_RELEASE: env_release_coef = value[15:0];
                REG_LOOKAHEAD:   lookahead_len    = value[10:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_LIMIT:       return 32'(limit_level);
                REG_ATTACK:      return 32'(attack_coef);
                REG_RELEASE:     return 32'(release_coef);
                REG_ENV_RELEASE: return 32'(env_release_coef);
                REG_LOOKAHEAD:   return 32'(lookahead_len);
                default:         return '0;
            endcase
        endfunction

        function void report(string what, longint want, longint got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        // Advances the limiter by one accepted sample and queues the output it must give.
        function void take_sample(logic signed [15:0] x);
            longint          mag;
            longint          env;
            longint          lim;
            longint          target;
            longint          g;
            longint          delayed;
            longint          y;
            int unsigned     len;
            int unsigned     idx;
            limiter_output_t res;

            mag = (x < 0) ? -longint'(x) : longint'(x);
            mag = mag << 8;
            env = longint'(envelope);
            if (mag > env)
                env = mag;
            else
                env -= (longint'(env_release_coef) * (env - mag) + 32768) >> 16;
            envelope = env[23:0];
            env = longint'(envelope);

            lim = longint'(limit_level) << 8;
            target = (env > lim) ? (lim << 16) / env : longint'(FULL_GAIN);

            g = longint'(gain);
            if (target < g)
                g -= (longint'(attack_coef) * (g - target) + 32768) >> 16;
            else
                g += (longint'(release_coef) * (target - g) + 32768) >> 16;
            gain = g[16:0];

            len = lookahead_len;
            if (len < 1)
                len = 1;
            if (len > DELAY_DEPTH)
                len = DELAY_DEPTH;
            // A shrunk length still uses the current slot once before wrapping.
            idx = wr_index % DELAY_DEPTH;
            delayed = longint'(delay_mem[idx]);
            delay_mem[idx] = x;
            wr_index = (idx + 1 >= len) ? 0 : idx + 1;

            y = (delayed * longint'(gain) + 32768) >>> 16;
            if (y > SAT_LEVEL)
                y = SAT_LEVEL;
            if (y < -SAT_LEVEL)
                y = -SAT_LEVEL;
            res.sample = y[15:0];
            res.gain   = gain;
            due_outputs.push_back(res);
        endfunction

        function void match_output(logic signed [15:0] s, logic [16:0] gn);
            limiter_output_t want;
            if (due_outputs.size() == 0)
            begin
                report("unexpected output sample_out", 0, s);
                return;
            end
            want = due_outputs.pop_front();
            if (s !== want.sample)
                report("sample_out", want.sample, s);
            if (gn !== want.gain)
                report("gain_now", want.gain, gn);
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic [GAIN_W-1:0]          gain_now;

    limiter_tracker tracker;
    int             in_idle_pct;
    int             out_idle_pct;
    int             hold_requests;
    int             hold_served;
    int             hold_left;
    int             cycle_count;

    lookahead_peak_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample_out(sample_out),
        .gain_now  (gain_now)
    );

    always #6 clk = ~clk;

    // Both channels are observed at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lookahead_peak_limiter verification failed");
            $finish;
        end
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.take_sample(sample_in);
            if (out_valid && !out_stall)
                tracker.match_output(sample_out, gain_now);
        end
    end

    // Output back-pressure: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    task automatic apb_access(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        apb_access(idx, 1'b1, value, readback);
        tracker.write_reg(idx, value);
        if (idx <= 3'(REG_LOOKAHEAD))
        begin
            apb_access(idx, 1'b0, '0, readback);
            if (readback !== tracker.reg_value(idx))
                tracker.report("register readback", tracker.reg_value(idx), readback);
        end
    endtask

    task automatic configure(input logic [31:0] limit, input logic [31:0] attack,
                             input logic [31:0] rel, input logic [31:0] env_rel,
                             input logic [31:0] len);
        set_reg(REG_LIMIT, limit);
        set_reg(REG_ATTACK, attack);
        set_reg(REG_RELEASE, rel);
        set_reg(REG_ENV_RELEASE, env_rel);
        set_reg(REG_LOOKAHEAD, len);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_sample(input logic signed [15:0] s);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid  = 1'b0;
            sample_in = 16'($urandom);
            @(negedge clk);
        end
        in_valid  = 1'b1;
        sample_in = s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (tracker.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_sample(burst_kind_t kind, int amp);
        int v;
        case (kind)
            BURST_LOUD:
                return 16'($urandom);
            BURST_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return -SAMPLE_MAX;
                    default: return '0;
                endcase
            end
            default:
            begin
                v = int'($urandom_range(0, 2 * amp)) - amp;
                return 16'(v);
            end
        endcase
    endfunction

    // Music-like material: bursts of quiet, moderate and loud passages with transients.
    task automatic run_programme(input int n_items);
        burst_kind_t kind;
        int          amp;
        int          burst_len;
        int          left;
        int          roll;
        left = n_items;
        while (left > 0)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 3)
                kind = BURST_QUIET;
            else if (roll < 7)
                kind = BURST_MID;
            else if (roll < 9)
                kind = BURST_LOUD;
            else
                kind = BURST_EXTREME;
            amp = (kind == BURST_QUIET) ? $urandom_range(1, 2000) : $urandom_range(8000, 32767);
            burst_len = $urandom_range(4, 80);
            while (burst_len > 0 && left > 0)
            begin
                send_sample(pick_sample(kind, amp));
                burst_len--;
                left--;
            end
        end
    endtask

    initial
    begin
        logic signed [15:0] directed [$];
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        sample_in     = '0;
        out_stall     = 1'b0;
        in_idle_pct   = 15;
        out_idle_pct  = 84;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        cycle_count   = 0;
        tracker       = new();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Short delay so that the extremes reach the output quickly; other registers at reset.
        set_reg(REG_LOOKAHEAD, 32'd3);
        set_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        directed = '{16'sd0, SAMPLE_MAX, SAMPLE_MIN, 16'sd1, -16'sd1, 16'sd29491, 16'sd29492,
                     -16'sd29492, 16'sd16384, -16'sd16384, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN,
                     16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd100, -16'sd100, 16'sh5555,
                     16'shAAAA, 16'sd0, 16'sd0, 16'sd0};
        foreach (directed[i])
            send_sample(directed[i]);
        drain();

        configure(32'd16384, 32'd20000, 32'd3000, 32'd2000, 32'd17);
        hold_requests++;
        run_programme(PHASE_ITEMS);
        drain();

        // A zero limit forces the desired gain to zero whenever the envelope is above zero.
        configure(32'd0, 32'd65535, 32'd65535, 32'd65535, 32'd1);
        run_programme(PHASE_ITEMS);
        drain();

        in_idle_pct  = 84;
        out_idle_pct = 15;
        configure(32'd32767, 32'd0, 32'd0, 32'd0, 32'd1024);
        run_programme(PHASE_ITEMS);
        drain();

        // A zero length acts as one; the write index is well past it here.
        configure(32'd8000, 32'd1000, 32'd500, 32'd300, 32'd0);
        run_programme(PHASE_ITEMS);
        drain();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_requests++;
        configure($urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
        run_programme(PHASE_ITEMS);
        drain();

        configure($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 64));
        run_programme(PHASE_ITEMS);

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.errors == 0)
            $display("lookahead_peak_limiter verification clean");
        else
            $display("lookahead_peak_limiter verification failed");
        $finish;
    end

endmodule
